// File: rtl/smslt_pkg.sv
// Shared widths, register indexes and reset values for the slew-limited trajectory block.
package smslt_pkg;

	localparam int POS_W      = 32;
	localparam int DELTA_W    = 27;
	localparam int DUR_W      = 30;
	localparam int SPEED_W    = 10;
	localparam int PERIOD_W   = 16;
	localparam int AXIS_W     = 2;
	localparam int STEP_W     = SPEED_W + PERIOD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd6;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	localparam logic signed [DELTA_W-1:0] DELTA_RST    = 27'sd10000000;
	localparam logic [DUR_W-1:0]          DURATION_RST = 30'd8000000;
	localparam logic [SPEED_W-1:0]        SPEED_RST    = 10'd10;

	localparam logic func_start = 1'b0;

endpackage

// File: rtl/smslt_div.sv
// Restoring divider, one quotient bit per cycle, for the normalised time.
module smslt_div #(
	parameter int QW = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smslt_pkg::DUR_W-1:0]   num,
	input  logic [smslt_pkg::DUR_W-1:0]   den,
	output logic                          done,
	output logic [QW-1:0]                 quo
);

	localparam int DW = smslt_pkg::DUR_W;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   rem2;
	logic [DW:0]   diff;
	logic          ge;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den};
	assign ge   = (rem2 >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem2[DW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/smslt_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, shared by every product.
module smslt_mul #(
	parameter int WA = 28,
	parameter int WB = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic             done,
	output logic [WA+WB-1:0] prod
);

	localparam int CW = $clog2(WB);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [WA:0]   hi_q;
	logic [WB-1:0] lo_q;
	logic [WA:0]   sum;

	// a must hold steady while busy
	assign sum = hi_q + (lo_q[0] ? {1'b0, a} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[WA:1]};
			lo_q <= {sum[0], lo_q[WB-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q[WA-1:0], lo_q};

endmodule

// File: rtl/smooth_move_slew_limited_trajectory.sv
// Top level: sequencer, state and axis update of the slew-limited minimum-jerk generator.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  func, period_us
//  out      source     out_valid/out_stall  cmd_x, cmd_y, cmd_z, finished
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
// A start item loads the start positions and then, in ST_OUT, the output
// register. A tick runs the bit-serial divider and four passes through the
// shared bit-serial multiplier; a tick whose time has reached the duration
// skips the divider and three products. in_stall is high from acceptance
// until the result is loaded; a stalled result holds the output register and
// the sequencer waits. Reset clears state, time and the last positions, and
// loads the register defaults; the command outputs have no reset.
module smooth_move_slew_limited_trajectory #(
	parameter int TAU_FRAC_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  func,
	input  logic [smslt_pkg::PERIOD_W-1:0]        period_us,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [smslt_pkg::POS_W-1:0]    cmd_x,
	output logic signed [smslt_pkg::POS_W-1:0]    cmd_y,
	output logic signed [smslt_pkg::POS_W-1:0]    cmd_z,
	output logic                                  finished,
	input  logic                                  cfg_we,
	input  logic [smslt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smslt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int F       = TAU_FRAC_BITS;
	localparam int POS_W   = smslt_pkg::POS_W;
	localparam int DELTA_W = smslt_pkg::DELTA_W;
	localparam int DUR_W   = smslt_pkg::DUR_W;
	localparam int SPEED_W = smslt_pkg::SPEED_W;
	localparam int STEP_W  = smslt_pkg::STEP_W;
	localparam int WA      = F + 4;
	localparam int WB      = (F > DELTA_W) ? F : DELTA_W;
	localparam int PW      = WA + WB;
	localparam int TW      = POS_W + 1;
	localparam int DFW     = POS_W + 2;

	localparam logic [WA-1:0] ONE     = WA'(1) << F;
	localparam logic [WA-1:0] TEN_ONE = WA'(10) << F;
	localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TIME = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_POLA = 4'd5;
	localparam logic [3:0] ST_POLB = 4'd6;
	localparam logic [3:0] ST_M3   = 4'd7;
	localparam logic [3:0] ST_M4   = 4'd8;
	localparam logic [3:0] ST_RND  = 4'd9;
	localparam logic [3:0] ST_TGT  = 4'd10;
	localparam logic [3:0] ST_AXD  = 4'd11;
	localparam logic [3:0] ST_AXU  = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	// configuration
	logic signed [POS_W-1:0]        start_x_q, start_y_q, start_z_q;
	logic [smslt_pkg::AXIS_W-1:0]   axis_q;
	logic signed [DELTA_W-1:0]      delta_q;
	logic [DUR_W-1:0]               dur_q;
	logic [SPEED_W-1:0]             speed_q;

	// state and working registers
	logic [3:0]                     state_q;
	logic [DUR_W-1:0]               elapsed_q;
	logic [DUR_W:0]                 esum_q;
	logic [STEP_W-1:0]              step_q;
	logic                           fin_q;
	logic signed [POS_W-1:0]        last_q [3];
	logic [F-1:0]                   tau_q;
	logic [F-1:0]                   t2_q;
	logic [F-1:0]                   t3_q;
	logic [WA-1:0]                  pa_q;
	logic [DELTA_W-1:0]             rnd_q;
	logic signed [TW-1:0]           tgt_q;
	logic signed [DFW-1:0]          dif_q;
	logic [1:0]                     ax_q;
	logic                           mul_start_q;
	logic [WA-1:0]                  mul_a_q;
	logic [WB-1:0]                  mul_b_q;
	logic                           div_start_q;

	// output register
	logic                           out_valid_q;
	logic signed [POS_W-1:0]        cmd_x_q, cmd_y_q, cmd_z_q;
	logic                           fin_out_q;

	logic                           mul_done;
	logic [PW-1:0]                  mul_prod;
	logic                           div_done;
	logic [F-1:0]                   div_quo;

	logic                           at_end;
	logic                           mul_go;
	logic                           div_go;
	logic                           neg;
	logic [DELTA_W-1:0]             mag;
	logic [WA-1:0]                  sraw;
	logic [WA-1:0]                  s_cap;
	logic [PW-1:0]                  rsum;
	logic signed [POS_W-1:0]        start_mv;
	logic signed [POS_W-1:0]        start_ax;
	logic signed [TW-1:0]           desired;
	logic signed [DFW-1:0]          step_s;
	logic signed [DFW-1:0]          d_clamp;
	logic signed [DFW-1:0]          nw;
	logic signed [POS_W-1:0]        nw_sat;

	smslt_mul #(.WA(WA), .WB(WB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	smslt_div #(.QW(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (esum_q[DUR_W-1:0]),
		.den    (dur_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign at_end = (esum_q >= {1'b0, dur_q});
	assign mul_go = (state_q == ST_TIME && at_end) || (state_q == ST_DIV && div_done) ||
	                ((state_q == ST_M1 || state_q == ST_M3) && mul_done) ||
	                (state_q == ST_POLB);
	assign div_go = (state_q == ST_TIME) && !at_end;

	assign neg   = delta_q[DELTA_W-1];
	assign mag   = neg ? (~delta_q + 1'b1) : delta_q;
	assign sraw  = mul_prod[F +: WA];
	assign s_cap = (sraw > ONE) ? ONE : sraw;
	assign rsum  = mul_prod + HALF;

	always_comb begin
		unique case (axis_q)
			smslt_pkg::AXIS_X: start_mv = start_x_q;
			smslt_pkg::AXIS_Y: start_mv = start_y_q;
			default:           start_mv = start_z_q;
		endcase
	end

	always_comb begin
		unique case (ax_q)
			smslt_pkg::AXIS_X: start_ax = start_x_q;
			smslt_pkg::AXIS_Y: start_ax = start_y_q;
			default:           start_ax = start_z_q;
		endcase
	end

	assign desired = (axis_q == ax_q) ? tgt_q : TW'(start_ax);

	assign step_s = signed'(DFW'(step_q));

	always_comb begin
		if (dif_q > step_s)
			d_clamp = step_s;
		else if (dif_q < -step_s)
			d_clamp = -step_s;
		else
			d_clamp = dif_q;
		nw = DFW'(last_q[ax_q]) + d_clamp;
		if (nw[DFW-1:POS_W-1] == '0 || nw[DFW-1:POS_W-1] == '1)
			nw_sat = nw[POS_W-1:0];
		else if (nw[DFW-1])
			nw_sat = {1'b1, {(POS_W-1){1'b0}}};
		else
			nw_sat = {1'b0, {(POS_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			axis_q    <= smslt_pkg::AXIS_X;
			delta_q   <= smslt_pkg::DELTA_RST;
			dur_q     <= smslt_pkg::DURATION_RST;
			speed_q   <= smslt_pkg::SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				smslt_pkg::CFG_START_X:  start_x_q <= cfg_data[POS_W-1:0];
				smslt_pkg::CFG_START_Y:  start_y_q <= cfg_data[POS_W-1:0];
				smslt_pkg::CFG_START_Z:  start_z_q <= cfg_data[POS_W-1:0];
				smslt_pkg::CFG_AXIS:     axis_q    <= cfg_data[smslt_pkg::AXIS_W-1:0];
				smslt_pkg::CFG_DELTA:    delta_q   <= cfg_data[DELTA_W-1:0];
				smslt_pkg::CFG_DURATION: dur_q     <= cfg_data[DUR_W-1:0];
				smslt_pkg::CFG_SPEED:    speed_q   <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			elapsed_q   <= '0;
			last_q[0]   <= '0;
			last_q[1]   <= '0;
			last_q[2]   <= '0;
			fin_q       <= 1'b0;
			ax_q        <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= mul_go;
			div_start_q <= div_go;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (func == smslt_pkg::func_start) begin
							elapsed_q <= '0;
							last_q[0] <= start_x_q;
							last_q[1] <= start_y_q;
							last_q[2] <= start_z_q;
							fin_q     <= 1'b0;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_TIME;
						end
					end
				end
				ST_TIME: begin
					ax_q <= '0;
					if (at_end) begin
						elapsed_q   <= dur_q;
						fin_q       <= 1'b1;
						mul_a_q     <= ONE;
						mul_b_q     <= WB'(mag);
						state_q     <= ST_M4;
					end else begin
						elapsed_q   <= esum_q[DUR_W-1:0];
						fin_q       <= 1'b0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						mul_a_q     <= WA'(div_quo);
						mul_b_q     <= WB'(div_quo);
						state_q     <= ST_M1;
					end
				end
				ST_M1: begin
					if (mul_done) begin
						mul_a_q     <= WA'(mul_prod[F +: F]);
						mul_b_q     <= WB'(tau_q);
						state_q     <= ST_M2;
					end
				end
				ST_M2: begin
					if (mul_done)
						state_q <= ST_POLA;
				end
				ST_POLA: begin
					state_q <= ST_POLB;
				end
				ST_POLB: begin
					// 10 - 15 tau + 6 tau^2, exact modulo the result width
					mul_a_q     <= pa_q + {t2_q, 2'b00} + {t2_q, 1'b0};
					mul_b_q     <= WB'(t3_q);
					state_q     <= ST_M3;
				end
				ST_M3: begin
					if (mul_done) begin
						mul_a_q     <= s_cap;
						mul_b_q     <= WB'(mag);
						state_q     <= ST_M4;
					end
				end
				ST_M4: begin
					if (mul_done)
						state_q <= ST_RND;
				end
				ST_RND: begin
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					state_q <= ST_AXD;
				end
				ST_AXD: begin
					state_q <= ST_AXU;
				end
				ST_AXU: begin
					last_q[ax_q] <= nw_sat;
					if (ax_q == smslt_pkg::AXIS_Z) begin
						state_q <= ST_OUT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_AXD;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			esum_q <= {1'b0, elapsed_q} + (DUR_W + 1)'(period_us);
			step_q <= STEP_W'(speed_q) * STEP_W'(period_us);
		end
		if (state_q == ST_DIV && div_done)
			tau_q <= div_quo;
		if (state_q == ST_M1 && mul_done)
			t2_q <= mul_prod[F +: F];
		if (state_q == ST_M2 && mul_done)
			t3_q <= mul_prod[F +: F];
		if (state_q == ST_POLA)
			pa_q <= TEN_ONE - {tau_q, 4'b0000} + WA'(tau_q);
		if (state_q == ST_RND)
			rnd_q <= rsum[F +: DELTA_W];
		if (state_q == ST_TGT)
			tgt_q <= neg ? (TW'(start_mv) - signed'(TW'(rnd_q)))
			             : (TW'(start_mv) + signed'(TW'(rnd_q)));
		if (state_q == ST_AXD)
			dif_q <= DFW'(desired) - DFW'(last_q[ax_q]);
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			cmd_x_q   <= last_q[0];
			cmd_y_q   <= last_q[1];
			cmd_z_q   <= last_q[2];
			fin_out_q <= fin_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd_x     = cmd_x_q;
	assign cmd_y     = cmd_y_q;
	assign cmd_z     = cmd_z_q;
	assign finished  = fin_out_q;

endmodule
